@@ rtl/tile_quad_resolver_assert.svh @@
// ----------------------------------------------------------------------------
// tile_quad_resolver_assert.svh
// Assertion macros used by the checker file of the tile quad resolver.
// ----------------------------------------------------------------------------
`ifndef TILE_QUAD_RESOLVER_ASSERT_SVH
`define TILE_QUAD_RESOLVER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define TQR_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tile_quad_resolver: assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define TQR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tile_quad_resolver: assertion failed");

`endif

@@ rtl/tqr_pkg.sv @@
// ----------------------------------------------------------------------------
// tqr_pkg
// Types and constants of the tile quad resolver: item structs, register
// indexes, table entry layout and pipeline depths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tqr_pkg;

    // field widths
    localparam int ID_W     = 29;
    localparam int UV_W     = 18;
    localparam int ADDR_W   = 5;

    // fixed limits
    localparam logic [UV_W-1:0] UV_MAX = 18'h3FFFF;
    localparam logic [7:0]      CS_DEFAULT = 8'd16;
    localparam int              LAYER_DIM_MAX = 1024;

    // pipeline depths of the divider sections
    localparam int ROW_STAGES = 8;
    localparam int UV_STAGES  = 5;

    // item kind
    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_CELL = 1'b1
    } mode_t;

    // register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_MAP_TILE_W    = 3'd0,
        REG_MAP_TILE_H    = 3'd1,
        REG_LAYER_WIDTH   = 3'd2,
        REG_CHUNK_SIZE    = 3'd3,
        REG_TILESET_COUNT = 3'd4
    } reg_idx_t;

    typedef struct packed {
        mode_t            mode;
        logic [2:0]       entry_index;
        logic [ID_W-1:0]  entry_first_id;
        logic [9:0]       entry_columns;
        logic [9:0]       entry_tile_w;
        logic [9:0]       entry_tile_h;
        logic [15:0]      entry_image_w;
        logic [15:0]      entry_image_h;
        logic [9:0]       cell_x;
        logic [9:0]       cell_y;
        logic [31:0]      cell_tile_id;
    } in_item_t;

    typedef struct packed {
        logic             drawn;
        logic [2:0]       tileset_index;
        logic [19:0]      chunk_index;
        logic [9:0]       tile_col;
        logic [ID_W-1:0]  tile_row;
        logic [UV_W-1:0]  uv_left;
        logic [UV_W-1:0]  uv_top;
        logic [UV_W-1:0]  uv_right;
        logic [UV_W-1:0]  uv_bottom;
        logic [20:0]      centre_x;
        logic [20:0]      centre_y;
    } out_item_t;

    typedef struct packed {
        logic [ID_W-1:0]  first_id;
        logic [9:0]       columns;
        logic [9:0]       tile_w;
        logic [9:0]       tile_h;
        logic [15:0]      image_w;
        logic [15:0]      image_h;
    } entry_t;

endpackage

`default_nettype wire

@@ rtl/tile_quad_resolver.sv @@
// Tile quad resolver: takes one item per clock. A load item writes one
// tileset entry and yields nothing; a cell item yields one result after
// it passes the input register, tileset search, id offset, an 8-stage
// row/column divider, product and range-check stages, 5-stage
// texture-coordinate and chunk dividers and the output register. Most of
// the depth lies in the two pipelined restoring dividers; throughput is one
// item per cycle as long as the result side takes items. A stalled result
// freezes the whole pipeline, and the input is stalled in the same cycle.
// ----------------------------------------------------------------------------
// tile_quad_resolver
// Resolves tile map cells to tileset uv quads, chunk index and quad centre.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tile_quad_resolver #(
    parameter int MAX_TILESETS = 8
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cell_valid,
    output logic                            cell_stall,
    input  wire tqr_pkg::in_item_t          cell_item,
    output logic                            quad_valid,
    input  wire logic                       quad_stall,
    output tqr_pkg::out_item_t              quad_item,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [tqr_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready
);

    import tqr_pkg::*;

    localparam int IW = (MAX_TILESETS > 1) ? $clog2(MAX_TILESETS) : 1;

    typedef struct packed {
        logic            ok;
        logic [IW-1:0]   best;
        logic [9:0]      x;
        logic [9:0]      y;
        logic [9:0]      tw;
        logic [9:0]      th;
        logic [15:0]     iw;
        logic [15:0]     ih;
    } side_t;

    typedef struct packed {
        side_t           side;
        logic [ID_W-1:0] loc_id;
        logic [9:0]      columns;
    } c_t;

    typedef struct packed {
        logic            ok;
        logic [IW-1:0]   best;
        logic [ID_W-1:0] id;
        entry_t          ent;
        logic [9:0]      x;
        logic [9:0]      y;
    } b_t;

    typedef struct packed {
        logic             ok;
        logic [IW-1:0]    best;
        logic [9:0]       x;
        logic [9:0]       y;
        logic [15:0]      iw;
        logic [15:0]      ih;
        logic [9:0]       col;
        logic [ID_W-1:0]  row;
        logic [3:0][39:0] num;
        logic [20:0]      cx;
        logic [20:0]      cy;
    } m_t;

    typedef struct packed {
        logic             ok;
        logic [IW-1:0]    best;
        logic [9:0]       col;
        logic [ID_W-1:0]  row;
        logic [20:0]      cx;
        logic [20:0]      cy;
        logic [3:0]       sat;
    } tail_t;

    typedef struct packed {
        tail_t            tail;
        logic [9:0]       x;
        logic [9:0]       y;
        logic [3:0][16:0] r0;
        logic [3:0][17:0] lo;
        logic [3:0][16:0] dv;
    } p_t;

    // configuration registers
    logic [9:0]  map_tile_w_reg;
    logic [9:0]  map_tile_h_reg;
    logic [10:0] layer_width_reg;
    logic [7:0]  chunk_size_reg;
    logic [3:0]  tileset_count_reg;
    logic        cfg_wr;
    reg_idx_t    cfg_idx;

    // pipeline
    logic                 en;
    logic                 a_valid_reg;
    in_item_t             a_reg;
    entry_t               tab_reg [MAX_TILESETS];
    logic                 b_valid_reg;
    b_t                   b_reg;
    b_t                   b_next;
    logic                 c_valid_reg;
    c_t                   c_reg;
    logic [ROW_STAGES-1:0] sv_reg;
    side_t                side_reg [ROW_STAGES];
    logic                 m_valid_reg;
    m_t                   m_reg;
    m_t                   m_next;
    logic                 p_valid_reg;
    p_t                   p_reg;
    p_t                   p_next;
    logic [UV_STAGES-1:0] tv_reg;
    tail_t                tail_reg [UV_STAGES];
    logic                 o_valid_reg;
    out_item_t            o_reg;
    out_item_t            o_next;

    logic [ID_W-1:0]         a_id;
    logic [MAX_TILESETS-1:0] cand;
    logic [MAX_TILESETS-1:0] win;
    entry_t                  sel_ent;
    logic [IW-1:0]           sel_idx;
    logic [ID_W-1:0]         row_q;
    logic [9:0]              col_r;
    logic [3:0][UV_W-1:0]    uv_q;
    logic [3:0][16:0]        uv_r;
    logic [9:0]              xq;
    logic [9:0]              yq;
    logic [11:0]             colsq;
    logic [7:0]              xr;
    logic [7:0]              yr;
    logic [7:0]              colsr;
    logic [7:0]              cs_eff;
    logic [10:0]             w_eff;
    logic [11:0]             cols_num;
    side_t                   s_last;
    tail_t                   t_last;

    // register port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_tile_w_reg    <= 10'd16;
            map_tile_h_reg    <= 10'd16;
            layer_width_reg   <= 11'd1;
            chunk_size_reg    <= 8'd16;
            tileset_count_reg <= 4'd0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_MAP_TILE_W:    map_tile_w_reg    <= pwdata[9:0];
                REG_MAP_TILE_H:    map_tile_h_reg    <= pwdata[9:0];
                REG_LAYER_WIDTH:   layer_width_reg   <= pwdata[10:0];
                REG_CHUNK_SIZE:    chunk_size_reg    <= pwdata[7:0];
                REG_TILESET_COUNT: tileset_count_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_MAP_TILE_W:    prdata = 32'(map_tile_w_reg);
            REG_MAP_TILE_H:    prdata = 32'(map_tile_h_reg);
            REG_LAYER_WIDTH:   prdata = 32'(layer_width_reg);
            REG_CHUNK_SIZE:    prdata = 32'(chunk_size_reg);
            REG_TILESET_COUNT: prdata = 32'(tileset_count_reg);
            default:           prdata = '0;
        endcase
    end

    // whole pipeline moves unless a finished item is held at the output
    assign en         = !(o_valid_reg && quad_stall);
    assign cell_stall = !en;

    // tileset table, written by load items in order with cell lookups
    always_ff @(posedge clk)
    begin
        if (en && a_valid_reg && a_reg.mode == MODE_LOAD &&
            32'(a_reg.entry_index) < 32'(MAX_TILESETS))
        begin
            tab_reg[IW'(a_reg.entry_index)] <= '{
                first_id: a_reg.entry_first_id,
                columns:  a_reg.entry_columns,
                tile_w:   a_reg.entry_tile_w,
                tile_h:   a_reg.entry_tile_h,
                image_w:  a_reg.entry_image_w,
                image_h:  a_reg.entry_image_h
            };
        end
    end

    // search: largest first id not above the cell id, lower index on a tie
    assign a_id = a_reg.cell_tile_id[ID_W-1:0];

    always_comb
    begin
        for (int i = 0; i < MAX_TILESETS; i++)
        begin
            cand[i] = (32'(tileset_count_reg) > 32'(i)) && (a_id >= tab_reg[i].first_id);
        end
        for (int i = 0; i < MAX_TILESETS; i++)
        begin
            win[i] = cand[i];
            for (int j = 0; j < MAX_TILESETS; j++)
            begin
                if (j != i && cand[j] &&
                    (tab_reg[j].first_id > tab_reg[i].first_id ||
                     (tab_reg[j].first_id == tab_reg[i].first_id && j < i)))
                begin
                    win[i] = 1'b0;
                end
            end
        end
        sel_ent = '0;
        sel_idx = '0;
        for (int i = 0; i < MAX_TILESETS; i++)
        begin
            if (win[i])
            begin
                sel_ent = sel_ent | tab_reg[i];
                sel_idx = sel_idx | IW'(i);
            end
        end
        b_next.ok   = (a_id != '0) && (|win) && (sel_ent.columns != '0) &&
                      (sel_ent.image_w != '0) && (sel_ent.image_h != '0);
        b_next.best = sel_idx;
        b_next.id   = a_id;
        b_next.ent  = sel_ent;
        b_next.x    = a_reg.cell_x;
        b_next.y    = a_reg.cell_y;
    end

    // front stages: input, search, id offset
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg             <= cell_item;
            b_reg             <= b_next;
            c_reg.side.ok     <= b_reg.ok;
            c_reg.side.best   <= b_reg.best;
            c_reg.side.x      <= b_reg.x;
            c_reg.side.y      <= b_reg.y;
            c_reg.side.tw     <= b_reg.ent.tile_w;
            c_reg.side.th     <= b_reg.ent.tile_h;
            c_reg.side.iw     <= b_reg.ent.image_w;
            c_reg.side.ih     <= b_reg.ent.image_h;
            c_reg.loc_id      <= b_reg.id - b_reg.ent.first_id;
            c_reg.columns     <= b_reg.ent.columns;
        end
    end

    // tile row and column
    tqr_div #(.DW(10), .QW(ID_W), .STAGES(ROW_STAGES)) u_row_div (
        .clk (clk),
        .en  (en),
        .r0  (10'd0),
        .lo  (c_reg.loc_id),
        .d   (c_reg.columns),
        .q   (row_q),
        .r   (col_r)
    );

    assign s_last = side_reg[ROW_STAGES-1];

    // products for the uv numerators and the quad centre
    always_comb
    begin
        m_next.ok     = s_last.ok;
        m_next.best   = s_last.best;
        m_next.x      = s_last.x;
        m_next.y      = s_last.y;
        m_next.iw     = s_last.iw;
        m_next.ih     = s_last.ih;
        m_next.col    = col_r;
        m_next.row    = row_q;
        m_next.num[0] = 40'(col_r) * 40'(s_last.tw);
        m_next.num[1] = 40'(row_q) * 40'(s_last.th);
        m_next.num[2] = (40'(col_r) + 40'd1) * 40'(s_last.tw);
        m_next.num[3] = (40'(row_q) + 40'd1) * 40'(s_last.th);
        m_next.cx     = 21'({s_last.x, 1'b1}) * 21'(map_tile_w_reg);
        m_next.cy     = 21'({s_last.y, 1'b1}) * 21'(map_tile_h_reg);
    end

    // uv dividend num*2^17 + den over 2*den, with the saturation check
    always_comb
    begin
        logic [15:0] den;
        p_next.tail.ok   = m_reg.ok;
        p_next.tail.best = m_reg.best;
        p_next.tail.col  = m_reg.col;
        p_next.tail.row  = m_reg.row;
        p_next.tail.cx   = m_reg.cx;
        p_next.tail.cy   = m_reg.cy;
        p_next.x         = m_reg.x;
        p_next.y         = m_reg.y;
        for (int k = 0; k < 4; k++)
        begin
            den = (k == 0 || k == 2) ? m_reg.iw : m_reg.ih;
            p_next.tail.sat[k] = m_reg.num[k][39:1] >= 39'({den, 1'b0});
            p_next.r0[k]       = m_reg.num[k][17:1];
            p_next.lo[k]       = {m_reg.num[k][0], 1'b0, den};
            p_next.dv[k]       = {den, 1'b0};
        end
    end

    // middle stages and side data along the dividers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= c_reg.side;
            for (int k = 1; k < ROW_STAGES; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
            m_reg       <= m_next;
            p_reg       <= p_next;
            tail_reg[0] <= p_reg.tail;
            for (int k = 1; k < UV_STAGES; k++)
            begin
                tail_reg[k] <= tail_reg[k-1];
            end
            o_reg       <= o_next;
        end
    end

    // texture coordinate lanes: left, top, right, bottom
    for (genvar k = 0; k < 4; k++)
    begin : g_uv
        tqr_div #(.DW(17), .QW(UV_W), .STAGES(UV_STAGES)) u_uv_div (
            .clk (clk),
            .en  (en),
            .r0  (p_reg.r0[k]),
            .lo  (p_reg.lo[k]),
            .d   (p_reg.dv[k]),
            .q   (uv_q[k]),
            .r   (uv_r[k])
        );
    end

    // chunk geometry from the live configuration
    always_comb
    begin
        cs_eff = (chunk_size_reg == '0) ? CS_DEFAULT : chunk_size_reg;
        if (layer_width_reg == '0)
        begin
            w_eff = 11'd1;
        end
        else if (32'(layer_width_reg) > LAYER_DIM_MAX)
        begin
            w_eff = 11'(LAYER_DIM_MAX);
        end
        else
        begin
            w_eff = layer_width_reg;
        end
        cols_num = 12'(w_eff) + 12'(cs_eff) - 12'd1;
    end

    tqr_div #(.DW(8), .QW(10), .STAGES(UV_STAGES)) u_x_div (
        .clk (clk),
        .en  (en),
        .r0  (8'd0),
        .lo  (p_reg.x),
        .d   (cs_eff),
        .q   (xq),
        .r   (xr)
    );

    tqr_div #(.DW(8), .QW(10), .STAGES(UV_STAGES)) u_y_div (
        .clk (clk),
        .en  (en),
        .r0  (8'd0),
        .lo  (p_reg.y),
        .d   (cs_eff),
        .q   (yq),
        .r   (yr)
    );

    tqr_div #(.DW(8), .QW(12), .STAGES(UV_STAGES)) u_cols_div (
        .clk (clk),
        .en  (en),
        .r0  (8'd0),
        .lo  (cols_num),
        .d   (cs_eff),
        .q   (colsq),
        .r   (colsr)
    );

    // result assembly: saturation, chunk index, undrawn cells read as zero
    assign t_last = tail_reg[UV_STAGES-1];

    always_comb
    begin
        o_next = '0;
        if (t_last.ok)
        begin
            o_next.drawn         = 1'b1;
            o_next.tileset_index = 3'(t_last.best);
            o_next.chunk_index   = 20'(23'(yq) * 23'(colsq) + 23'(xq));
            o_next.tile_col      = t_last.col;
            o_next.tile_row      = t_last.row;
            o_next.uv_left       = t_last.sat[0] ? UV_MAX : uv_q[0];
            o_next.uv_top        = t_last.sat[1] ? UV_MAX : uv_q[1];
            o_next.uv_right      = t_last.sat[2] ? UV_MAX : uv_q[2];
            o_next.uv_bottom     = t_last.sat[3] ? UV_MAX : uv_q[3];
            o_next.centre_x      = t_last.cx;
            o_next.centre_y      = t_last.cy;
        end
    end

    // valid bits; load items leave the pipeline after the table write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            sv_reg      <= '0;
            m_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            tv_reg      <= '0;
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= cell_valid;
            b_valid_reg <= a_valid_reg && (a_reg.mode == MODE_CELL);
            c_valid_reg <= b_valid_reg;
            sv_reg      <= {sv_reg[ROW_STAGES-2:0], c_valid_reg};
            m_valid_reg <= sv_reg[ROW_STAGES-1];
            p_valid_reg <= m_valid_reg;
            tv_reg      <= {tv_reg[UV_STAGES-2:0], p_valid_reg};
            o_valid_reg <= tv_reg[UV_STAGES-1];
        end
    end

    assign quad_valid = o_valid_reg;
    assign quad_item  = o_reg;

endmodule

`default_nettype wire

@@ rtl/tqr_div.sv @@
// ----------------------------------------------------------------------------
// tqr_div
// Pipelined restoring divider. Shifts QW dividend bits into a remainder that
// starts below the divisor, up to ceil(QW/STAGES) steps per register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tqr_div #(
    parameter int DW     = 10,
    parameter int QW     = 29,
    parameter int STAGES = 8
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [DW-1:0] r0,
    input  wire logic [QW-1:0] lo,
    input  wire logic [DW-1:0] d,
    output logic      [QW-1:0] q,
    output logic      [DW-1:0] r
);

    localparam int SPS = (QW + STAGES - 1) / STAGES;

    logic [DW-1:0] r_reg   [STAGES];
    logic [QW-1:0] lo_reg  [STAGES];
    logic [QW-1:0] q_reg   [STAGES];
    logic [DW-1:0] d_reg   [STAGES];
    logic [DW-1:0] r_next  [STAGES];
    logic [QW-1:0] lo_next [STAGES];
    logic [QW-1:0] q_next  [STAGES];
    logic [DW-1:0] src_r   [STAGES+1];
    logic [QW-1:0] src_lo  [STAGES+1];
    logic [QW-1:0] src_q   [STAGES+1];
    logic [DW-1:0] src_d   [STAGES+1];

    // divide steps of every stage
    always_comb
    begin
        logic [DW:0]   t;
        logic [DW-1:0] rv;
        logic [QW-1:0] lv;
        logic [QW-1:0] qv;
        src_r[0]  = r0;
        src_lo[0] = lo;
        src_q[0]  = '0;
        src_d[0]  = d;
        for (int s = 0; s < STAGES; s++)
        begin
            src_r[s+1]  = r_reg[s];
            src_lo[s+1] = lo_reg[s];
            src_q[s+1]  = q_reg[s];
            src_d[s+1]  = d_reg[s];
        end
        for (int s = 0; s < STAGES; s++)
        begin
            rv = src_r[s];
            lv = src_lo[s];
            qv = src_q[s];
            t  = '0;
            for (int k = 0; k < SPS; k++)
            begin
                if (s * SPS + k < QW)
                begin
                    t  = {rv, lv[QW-1]};
                    lv = {lv[QW-2:0], 1'b0};
                    if (t >= {1'b0, src_d[s]})
                    begin
                        rv = DW'(t - {1'b0, src_d[s]});
                        qv = {qv[QW-2:0], 1'b1};
                    end
                    else
                    begin
                        rv = t[DW-1:0];
                        qv = {qv[QW-2:0], 1'b0};
                    end
                end
            end
            r_next[s]  = rv;
            lo_next[s] = lv;
            q_next[s]  = qv;
        end
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < STAGES; s++)
            begin
                r_reg[s]  <= r_next[s];
                lo_reg[s] <= lo_next[s];
                q_reg[s]  <= q_next[s];
                d_reg[s]  <= src_d[s];
            end
        end
    end

    assign q = q_reg[STAGES-1];
    assign r = r_reg[STAGES-1];

endmodule

`default_nettype wire

@@ rtl/tqr_checker.sv @@
// ----------------------------------------------------------------------------
// tqr_checker
// Port-level checks of the tile quad resolver, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "tile_quad_resolver_assert.svh"

module tqr_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               cell_valid,
    input wire logic               cell_stall,
    input wire logic               quad_valid,
    input wire logic               quad_stall,
    input wire tqr_pkg::out_item_t quad_item
);

    import tqr_pkg::*;

    // a held result stays put
    `TQR_ASSERT_NEXT(a_quad_hold, quad_valid && quad_stall, quad_valid && $stable(quad_item))

    // the input only stalls behind a stalled result
    `TQR_ASSERT_IMPL(a_stall_cause, cell_stall, quad_valid && quad_stall)

    // undrawn cells carry all-zero fields
    `TQR_ASSERT_IMPL(a_undrawn_zero, quad_valid && !quad_item.drawn, quad_item == '0)

    // texture rectangle is never inverted
    `TQR_ASSERT_IMPL(a_uv_order, quad_valid && quad_item.drawn, (quad_item.uv_left <= quad_item.uv_right) && (quad_item.uv_top <= quad_item.uv_bottom))

endmodule

bind tile_quad_resolver tqr_checker u_tqr_checker (.*);

`default_nettype wire

@@ tb/sv/tile_quad_resolver_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_quad_resolver_test
// Streams tileset loads and map cells through the resolver under random
// bursts and output stalls, predicts every quad in order and compares all
// result fields; registers are rewritten between phases over their extremes.
// ----------------------------------------------------------------------------

module tile_quad_resolver_test;

    import tqr_pkg::*;

    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 25;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cell_valid = 1'b0;
    logic        cell_stall;
    in_item_t    cell_item = '0;
    logic        quad_valid;
    logic        quad_stall = 1'b0;
    out_item_t   quad_item;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // predictor copy of registers and tileset table
    logic [9:0]  cfg_tile_w = 10'd16;
    logic [9:0]  cfg_tile_h = 10'd16;
    logic [10:0] cfg_layer_w = 11'd1;
    logic [7:0]  cfg_chunk = 8'd16;
    logic [3:0]  cfg_count = 4'd0;
    entry_t      tileset_tab [8];

    in_item_t    cell_pending_q [$];
    out_item_t   quad_expect_q [$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          gap_left = 0;
    int          burst_left = 0;
    int          stall_phase = 0;
    int          stall_mode = 0;

    tile_quad_resolver dut (
        .clk(clk), .rst_n(rst_n),
        .cell_valid(cell_valid), .cell_stall(cell_stall), .cell_item(cell_item),
        .quad_valid(quad_valid), .quad_stall(quad_stall), .quad_item(quad_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // round half up of 65536 * num / den, saturated to UQ2.16
    function automatic logic [UV_W-1:0] uv_fix(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        q = ((num << 17) + den) / (den << 1);
        return (q > 64'd262143) ? UV_MAX : q[UV_W-1:0];
    endfunction

    // append one item to the sender's queue
    task automatic enqueue_cell(in_item_t it);
        cell_pending_q = {cell_pending_q, it};
    endtask

    // apply one accepted item to the table or queue its expected quad
    task automatic resolve_cell(in_item_t it);
        out_item_t   r;
        logic [28:0] id;
        logic [28:0] local_id;
        int          n;
        int          best;
        bit          found;
        entry_t      e;
        int unsigned cs;
        int unsigned w;
        int unsigned ccols;
        logic [63:0] col;
        logic [63:0] row;
        r = '0;
        found = 0;
        best = 0;
        if (it.mode == MODE_LOAD)
        begin
            tileset_tab[it.entry_index] = '{it.entry_first_id, it.entry_columns,
                it.entry_tile_w, it.entry_tile_h, it.entry_image_w, it.entry_image_h};
            return;
        end
        id = it.cell_tile_id[28:0];
        n = (cfg_count > 8) ? 8 : cfg_count;
        if (id != 0)
        begin
            for (int i = 0; i < n; i++)
            begin
                if (id >= tileset_tab[i].first_id &&
                    (!found || tileset_tab[i].first_id > tileset_tab[best].first_id))
                begin
                    best = i;
                    found = 1;
                end
            end
        end
        e = tileset_tab[best];
        if (found && e.columns != 0 && e.image_w != 0 && e.image_h != 0)
        begin
            cs = (cfg_chunk == 0) ? 16 : cfg_chunk;
            w = (cfg_layer_w == 0) ? 1 : ((cfg_layer_w > 1024) ? 1024 : cfg_layer_w);
            ccols = (w + cs - 1) / cs;
            local_id = id - e.first_id;
            col = local_id % e.columns;
            row = local_id / e.columns;
            r.drawn = 1'b1;
            r.tileset_index = best[2:0];
            r.chunk_index = 20'((it.cell_y / cs) * ccols + it.cell_x / cs);
            r.tile_col = col[9:0];
            r.tile_row = row[28:0];
            r.uv_left = uv_fix(col * e.tile_w, e.image_w);
            r.uv_top = uv_fix(row * e.tile_h, e.image_h);
            r.uv_right = uv_fix((col + 1) * e.tile_w, e.image_w);
            r.uv_bottom = uv_fix((row + 1) * e.tile_h, e.image_h);
            r.centre_x = 21'((2 * 64'(it.cell_x) + 1) * cfg_tile_w);
            r.centre_y = 21'((2 * 64'(it.cell_y) + 1) * cfg_tile_h);
        end
        quad_expect_q = {quad_expect_q, r};
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
        mismatches++;
    endtask

    // sender: bursts of items with random gaps
    always @(posedge clk)
    begin
        logic busy;
        if (!rst_n)
        begin
            cell_valid <= 1'b0;
        end
        else
        begin
            busy = cell_valid;
            if (cell_valid && !cell_stall)
            begin
                resolve_cell(cell_item);
                busy = 0;
            end
            if (!busy)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (cell_pending_q.size() > 0)
                begin
                    cell_item <= cell_pending_q.pop_front();
                    busy = 1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end
            end
            cell_valid <= busy;
        end
    end

    // receiver: stall pattern is redrawn whenever stall_phase wraps
    always @(posedge clk)
    begin
        out_item_t x;
        if (!rst_n)
        begin
            quad_stall <= 1'b0;
        end
        else
        begin
            if (quad_valid && !quad_stall)
            begin
                if (quad_expect_q.size() == 0)
                    report_mismatch("unexpected quad", 64'(quad_item.drawn), 64'd0);
                else
                begin
                    x = quad_expect_q.pop_front();
                    if (quad_item.drawn !== x.drawn)
                        report_mismatch("drawn", 64'(quad_item.drawn), 64'(x.drawn));
                    if (quad_item.tileset_index !== x.tileset_index)
                        report_mismatch("tileset_index", 64'(quad_item.tileset_index),
                                        64'(x.tileset_index));
                    if (quad_item.chunk_index !== x.chunk_index)
                        report_mismatch("chunk_index", 64'(quad_item.chunk_index),
                                        64'(x.chunk_index));
                    if (quad_item.tile_col !== x.tile_col)
                        report_mismatch("tile_col", 64'(quad_item.tile_col), 64'(x.tile_col));
                    if (quad_item.tile_row !== x.tile_row)
                        report_mismatch("tile_row", 64'(quad_item.tile_row), 64'(x.tile_row));
                    if (quad_item.uv_left !== x.uv_left)
                        report_mismatch("uv_left", 64'(quad_item.uv_left), 64'(x.uv_left));
                    if (quad_item.uv_top !== x.uv_top)
                        report_mismatch("uv_top", 64'(quad_item.uv_top), 64'(x.uv_top));
                    if (quad_item.uv_right !== x.uv_right)
                        report_mismatch("uv_right", 64'(quad_item.uv_right), 64'(x.uv_right));
                    if (quad_item.uv_bottom !== x.uv_bottom)
                        report_mismatch("uv_bottom", 64'(quad_item.uv_bottom),
                                        64'(x.uv_bottom));
                    if (quad_item.centre_x !== x.centre_x)
                        report_mismatch("centre_x", 64'(quad_item.centre_x), 64'(x.centre_x));
                    if (quad_item.centre_y !== x.centre_y)
                        report_mismatch("centre_y", 64'(quad_item.centre_y), 64'(x.centre_y));
                end
            end
            stall_phase++;
            if (stall_phase == 64)
            begin
                stall_phase = 0;
                stall_mode = $urandom_range(0, 2);
            end
            case (stall_mode)
                0: quad_stall <= 1'b0;
                1: quad_stall <= ($urandom_range(0, 9) < 3);
                default: quad_stall <= ($urandom_range(0, 9) < 8);
            endcase
        end
    end

    // watchdog on cycles with no handshake of any kind
    always @(posedge clk)
    begin
        if ((cell_valid && !cell_stall) || (quad_valid && !quad_stall) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(idx) << 2;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MAP_TILE_W:  cfg_tile_w = value[9:0];
            REG_MAP_TILE_H:  cfg_tile_h = value[9:0];
            REG_LAYER_WIDTH: cfg_layer_w = value[10:0];
            REG_CHUNK_SIZE:  cfg_chunk = value[7:0];
            default:         cfg_count = value[3:0];
        endcase
    endtask

    // wait until every sent item is taken and every quad has come back
    task automatic drain();
        while (cell_pending_q.size() > 0 || cell_valid || quad_expect_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic in_item_t make_load(int idx, logic [28:0] fid, logic [9:0] cols,
        logic [9:0] tw, logic [9:0] th, logic [15:0] iw, logic [15:0] ih);
        in_item_t it;
        it = '0;
        it.mode = MODE_LOAD;
        it.entry_index = idx[2:0];
        it.entry_first_id = fid;
        it.entry_columns = cols;
        it.entry_tile_w = tw;
        it.entry_tile_h = th;
        it.entry_image_w = iw;
        it.entry_image_h = ih;
        it.cell_x = 10'($urandom);
        it.cell_y = 10'($urandom);
        it.cell_tile_id = $urandom;
        return it;
    endfunction

    function automatic in_item_t make_cell(logic [9:0] x, logic [9:0] y, logic [31:0] id);
        in_item_t it;
        it = '0;
        it.mode = MODE_CELL;
        it.entry_index = 3'($urandom);
        it.entry_first_id = 29'($urandom);
        it.entry_columns = 10'($urandom);
        it.cell_x = x;
        it.cell_y = y;
        it.cell_tile_id = id;
        return it;
    endfunction

    function automatic in_item_t random_item();
        in_item_t    it;
        logic [31:0] id;
        int          k;
        if ($urandom_range(0, 9) == 0)
        begin
            it = make_load($urandom_range(0, 7),
                ($urandom_range(0, 1) != 0) ? 29'($urandom_range(0, 2000)) : 29'($urandom),
                ($urandom_range(0, 9) == 0) ? 10'd0 : 10'($urandom),
                10'($urandom), 10'($urandom),
                ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom),
                ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom));
            it.entry_tile_w = 10'($urandom);
            it.entry_tile_h = 10'($urandom);
            return it;
        end
        if ($urandom_range(0, 3) == 0)
            id = $urandom;
        else
        begin
            k = $urandom_range(0, 7);
            id = {3'($urandom), 29'(tileset_tab[k].first_id + $urandom_range(0, 3000))};
        end
        return make_cell(10'($urandom), 10'($urandom), id);
    endfunction

    initial
    begin
        int n;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: table with ties, undrawable entries and field extremes
        enqueue_cell(make_load(0, 29'd5, 10'd8, 10'd16, 10'd16, 16'd128, 16'd128));
        enqueue_cell(make_load(1, 29'd100, 10'd1023, 10'd1023, 10'd1023,
                               16'd1, 16'd1));
        enqueue_cell(make_load(2, 29'd200, 10'd4, 10'd32, 10'd32, 16'd128, 16'd96));
        enqueue_cell(make_load(3, 29'd200, 10'd5, 10'd8, 10'd8, 16'd40, 16'd40));
        enqueue_cell(make_load(4, 29'd300, 10'd0, 10'd8, 10'd8, 16'd64, 16'd64));
        enqueue_cell(make_load(5, 29'd400, 10'd4, 10'd8, 10'd8, 16'd0, 16'd64));
        enqueue_cell(make_load(6, 29'd500, 10'd4, 10'd8, 10'd8, 16'd64, 16'd0));
        enqueue_cell(make_load(7, 29'h1FFFFFFF, 10'd1023, 10'd1, 10'd1,
                               16'hFFFF, 16'hFFFF));
        drain();
        write_reg(REG_TILESET_COUNT, 32'd8);
        write_reg(REG_LAYER_WIDTH, 32'd1024);
        enqueue_cell(make_cell(10'd0, 10'd0, 32'd0));
        enqueue_cell(make_cell(10'd1023, 10'd1023, 32'hE0000000));
        enqueue_cell(make_cell(10'd3, 10'd4, 32'd3));
        enqueue_cell(make_cell(10'd1023, 10'd0, 32'd5));
        enqueue_cell(make_cell(10'd0, 10'd1023, 32'hA0000000 | 32'd77));
        enqueue_cell(make_cell(10'd17, 10'd33, 32'd150));
        enqueue_cell(make_cell(10'd5, 10'd6, 32'd299));
        enqueue_cell(make_cell(10'd7, 10'd8, 32'd301));
        enqueue_cell(make_cell(10'd9, 10'd10, 32'd450));
        enqueue_cell(make_cell(10'd11, 10'd12, 32'd555));
        enqueue_cell(make_cell(10'd1023, 10'd1023, 32'hFFFFFFFF));
        enqueue_cell(make_cell(10'd512, 10'd256, 32'h5FFFFFFF));
        drain();

        // random phases over register settings, extremes first
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0:
                begin
                    write_reg(REG_MAP_TILE_W, 32'd1);
                    write_reg(REG_MAP_TILE_H, 32'd1);
                    write_reg(REG_LAYER_WIDTH, 32'd1);
                    write_reg(REG_CHUNK_SIZE, 32'd1);
                    write_reg(REG_TILESET_COUNT, 32'd0);
                end
                1:
                begin
                    write_reg(REG_MAP_TILE_W, 32'd1023);
                    write_reg(REG_MAP_TILE_H, 32'd1023);
                    write_reg(REG_LAYER_WIDTH, 32'd1024);
                    write_reg(REG_CHUNK_SIZE, 32'd255);
                    write_reg(REG_TILESET_COUNT, 32'd8);
                end
                2:
                begin
                    write_reg(REG_MAP_TILE_W, 32'd0);
                    write_reg(REG_MAP_TILE_H, 32'd0);
                    write_reg(REG_LAYER_WIDTH, 32'd0);
                    write_reg(REG_CHUNK_SIZE, 32'd0);
                    write_reg(REG_TILESET_COUNT, 32'd15);
                end
                3:
                begin
                    write_reg(REG_LAYER_WIDTH, 32'd2047);
                    write_reg(REG_CHUNK_SIZE, 32'd7);
                    write_reg(REG_TILESET_COUNT, 32'd3);
                end
                default:
                begin
                    write_reg(REG_MAP_TILE_W, $urandom_range(1, 1023));
                    write_reg(REG_MAP_TILE_H, $urandom_range(1, 1023));
                    write_reg(REG_LAYER_WIDTH, $urandom_range(1, 1024));
                    write_reg(REG_CHUNK_SIZE, $urandom_range(1, 255));
                    write_reg(REG_TILESET_COUNT, $urandom_range(1, 8));
                end
            endcase
            n = 80;
            for (int i = 0; i < n; i++)
            begin
                enqueue_cell(random_item());
                // hold the sender once until every quad is back
                if (p == 4 && i == n / 2)
                begin
                    while (cell_pending_q.size() > 0 || cell_valid ||
                           quad_expect_q.size() > 0)
                        @(posedge clk);
                end
            end
            drain();
        end

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/tqr_pkg.sv
rtl/tqr_div.sv
rtl/tile_quad_resolver.sv
rtl/tqr_checker.sv
tb/sv/tile_quad_resolver_test.sv
